@@ rtl/core/psfp_pkg.sv @@
package psfp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h42;
	localparam logic [7:0] HDR_SECOND = 8'h4D;
	localparam logic [15:0] SUM_HDR   = 16'(HDR_FIRST) + 16'(HDR_SECOND);

	localparam int NUM_VALUES = 6;

	localparam logic [4:0] POS_LEN_HI    = 5'd2;
	localparam logic [4:0] POS_LEN_LO    = 5'd3;
	localparam logic [4:0] POS_VAL_FIRST = 5'd4;
	localparam logic [4:0] POS_VAL_LAST  = 5'd15;
	localparam logic [4:0] POS_CKSUM_HI  = 5'd30;
	localparam logic [4:0] POS_LAST      = 5'd31;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_SECOND  = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] pm1_standard;
		logic [15:0] pm2p5_standard;
		logic [15:0] pm10p0_standard;
		logic [15:0] pm1_env;
		logic [15:0] pm2p5_env;
		logic [15:0] pm10p0_env;
		logic        checksum_ok;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

	typedef struct packed {
		logic    frame_end;
		result_t result;
	} engine_out_t;

endpackage

@@ rtl/core/psfp_byte_if.sv @@
interface psfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/psfp_result_if.sv @@
interface psfp_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] frame_length;
	logic [15:0] pm1_standard;
	logic [15:0] pm2p5_standard;
	logic [15:0] pm10p0_standard;
	logic [15:0] pm1_env;
	logic [15:0] pm2p5_env;
	logic [15:0] pm10p0_env;
	logic        checksum_ok;

	modport source (
		output valid, output frame_length, output pm1_standard, output pm2p5_standard,
		output pm10p0_standard, output pm1_env, output pm2p5_env, output pm10p0_env,
		output checksum_ok, input ready
	);
	modport sink (
		input valid, input frame_length, input pm1_standard, input pm2p5_standard,
		input pm10p0_standard, input pm1_env, input pm2p5_env, input pm10p0_env,
		input checksum_ok, output ready
	);
endinterface

@@ rtl/core/psfp_input_stage.sv @@
module psfp_input_stage (
	input  logic              clk,
	input  logic              arst_n,
	psfp_byte_if.sink         rx,
	input  logic              advance,
	output psfp_pkg::stage_t  stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// stage is free when empty or when its byte is consumed this cycle
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule

@@ rtl/core/psfp_frame_engine.sv @@
module psfp_frame_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psfp_pkg::stage_t       stage,
	input  logic                   take,
	output psfp_pkg::engine_out_t  eng
);

	psfp_pkg::phase_t phase_q;
	logic [4:0]  pos_q;
	logic [15:0] sum_q;
	logic [15:0] length_q;
	logic [7:0]  cksum_hi_q;
	logic [15:0] pending_q [psfp_pkg::NUM_VALUES];
	logic [15:0] published_q [psfp_pkg::NUM_VALUES];

	logic [7:0]  b;
	logic        in_values;
	logic [4:0]  val_off;
	logic [2:0]  val_idx;
	logic        ok;
	logic [15:0] rep [psfp_pkg::NUM_VALUES];

	always_comb begin
		b         = stage.rx_byte;
		in_values = (pos_q >= psfp_pkg::POS_VAL_FIRST) && (pos_q <= psfp_pkg::POS_VAL_LAST);
		val_off   = pos_q - psfp_pkg::POS_VAL_FIRST;
		val_idx   = val_off[3:1];
		// low checksum byte is the current byte at the last position
		ok        = (sum_q == {cksum_hi_q, b});
		for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
			rep[i] = ok ? pending_q[i] : published_q[i];
		end
		eng.frame_end                  = stage.valid && (phase_q == psfp_pkg::PH_COLLECT)
			&& (pos_q == psfp_pkg::POS_LAST);
		eng.result.frame_length    = length_q;
		eng.result.pm1_standard    = rep[0];
		eng.result.pm2p5_standard  = rep[1];
		eng.result.pm10p0_standard = rep[2];
		eng.result.pm1_env         = rep[3];
		eng.result.pm2p5_env       = rep[4];
		eng.result.pm10p0_env      = rep[5];
		eng.result.checksum_ok     = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= psfp_pkg::PH_HUNT;
			pos_q    <= '0;
			sum_q    <= '0;
			length_q <= '0;
			cksum_hi_q <= '0;
			for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
				published_q[i] <= '0;
			end
		end else if (take) begin
			case (phase_q)
				psfp_pkg::PH_SECOND: begin
					if (b == psfp_pkg::HDR_SECOND) begin
						phase_q <= psfp_pkg::PH_COLLECT;
						pos_q   <= psfp_pkg::POS_LEN_HI;
						sum_q   <= psfp_pkg::SUM_HDR;
					end else begin
						phase_q <= psfp_pkg::PH_HUNT;
					end
				end
				psfp_pkg::PH_COLLECT: begin
					if (pos_q < psfp_pkg::POS_CKSUM_HI) begin
						sum_q <= sum_q + 16'(b);
					end
					if (pos_q == psfp_pkg::POS_LEN_HI) begin
						length_q[15:8] <= b;
					end
					if (pos_q == psfp_pkg::POS_LEN_LO) begin
						length_q[7:0] <= b;
					end
					if (pos_q == psfp_pkg::POS_CKSUM_HI) begin
						cksum_hi_q <= b;
					end
					if (pos_q == psfp_pkg::POS_LAST) begin
						phase_q <= psfp_pkg::PH_HUNT;
						pos_q   <= '0;
						if (ok) begin
							for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
								published_q[i] <= pending_q[i];
							end
						end
					end else begin
						pos_q <= pos_q + 5'd1;
					end
				end
				default: begin
					// unused phase code behaves as hunting
					phase_q <= (b == psfp_pkg::HDR_FIRST) ? psfp_pkg::PH_SECOND
						: psfp_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// this frame's concentrations, all rewritten before frame end
	always_ff @(posedge clk) begin
		if (take && (phase_q == psfp_pkg::PH_COLLECT) && in_values) begin
			for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
				if (val_idx == 3'(i)) begin
					if (!pos_q[0]) begin
						pending_q[i][15:8] <= b;
					end else begin
						pending_q[i][7:0] <= b;
					end
				end
			end
		end
	end

endmodule

@@ rtl/core/psfp_result_reg.sv @@
module psfp_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  psfp_pkg::result_t result,
	output logic              free,
	psfp_result_if.source     res
);

	logic              valid_q;
	psfp_pkg::result_t res_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign res.valid           = valid_q;
	assign res.frame_length    = res_q.frame_length;
	assign res.pm1_standard    = res_q.pm1_standard;
	assign res.pm2p5_standard  = res_q.pm2p5_standard;
	assign res.pm10p0_standard = res_q.pm10p0_standard;
	assign res.pm1_env         = res_q.pm1_env;
	assign res.pm2p5_env       = res_q.pm2p5_env;
	assign res.pm10p0_env      = res_q.pm10p0_env;
	assign res.checksum_ok     = res_q.checksum_ok;

endmodule

@@ rtl/core/particle_sensor_frame_parser.sv @@
// a result is registered in the result register after the input register takes the request carrying frame byte 31
// throughput: one byte per cycle; the input register frees up every cycle and only
//   holds when a frame ends while the previous result still waits at the output
// reset (arst_n low, asynchronous): parser hunts for the first header byte, sums, length
//   and checksum captures and published concentrations are zero, both register stages empty
module particle_sensor_frame_parser (
	input  logic          clk,
	input  logic          arst_n,
	psfp_byte_if.sink     rx,
	psfp_result_if.source res
);

	psfp_pkg::stage_t      stage;
	psfp_pkg::engine_out_t eng;
	logic                  out_free;
	logic                  advance;

	// the registered byte moves on unless it ends a frame and the output is still full
	assign advance = stage.valid && (!eng.frame_end || out_free);

	// input register: one received byte per request
	psfp_input_stage u_input (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.stage   (stage)
	);

	// header hunt, byte counter, running sum and field captures
	psfp_frame_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage),
		.take   (advance),
		.eng    (eng)
	);

	// result register, loaded once per completed frame
	psfp_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && eng.frame_end),
		.result (eng.result),
		.free   (out_free),
		.res    (res)
	);

endmodule
